// ===== rtl/source_line_classifier_macros.svh =====
// Assertion macros shared by the source line classifier RTL.
`ifndef SOURCE_LINE_CLASSIFIER_MACROS_SVH
`define SOURCE_LINE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slc_pkg.sv =====
// Shared types, constants and marker compare functions for the line classifier.
`default_nettype none

package slc_pkg;

  localparam int MarkerBytes = 8;
  localparam int CountBits   = 32;
  localparam int OutBits     = 32;
  localparam int WinBits     = 64;
  localparam int TlenBits    = 5;
  localparam int PscBits     = 4;
  localparam int CfgIdxBits  = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgSingle       = 3'd0,
    CfgSingleAlt    = 3'd1,
    CfgBlockOpen    = 3'd2,
    CfgBlockClose   = 3'd3,
    CfgBlockOpenAlt = 3'd4,
    CfgBlockCloseAlt = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ClassBlank   = 2'd0,
    ClassComment = 2'd1,
    ClassCode    = 2'd2
  } line_class_e;

  typedef struct packed {
    logic [WinBits-1:0] single_m;
    logic [WinBits-1:0] single_alt_m;
    logic [WinBits-1:0] open_m;
    logic [WinBits-1:0] close_m;
    logic [WinBits-1:0] open_alt_m;
    logic [WinBits-1:0] close_alt_m;
  } marker_set_t;

  // One completed line (or a bare end of file) handed to the classifier.
  typedef struct packed {
    logic                cls;
    logic                eof;
    logic [WinBits-1:0]  head;
    logic [WinBits-1:0]  tail;
    logic [TlenBits-1:0] tlen;
  } line_snap_t;

  // Leading nonzero bytes, counted from the top, capped at MarkerBytes.
  function automatic logic [3:0] marker_len(input logic [WinBits-1:0] m);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (run && (i < MarkerBytes) && (m[63-8*i -: 8] != 8'h00)) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic logic leads_with(input logic [WinBits-1:0] head,
                                      input logic [TlenBits-1:0] tlen,
                                      input logic [WinBits-1:0] m);
    logic [3:0] n;
    logic       hit;
    n   = marker_len(m);
    hit = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < n) && (head[63-8*i -: 8] != m[63-8*i -: 8])) begin
        hit = 1'b0;
      end
    end
    return (n != 4'd0) && (TlenBits'(n) <= tlen) && hit;
  endfunction

  function automatic logic trails_with(input logic [WinBits-1:0] tail,
                                       input logic [TlenBits-1:0] tlen,
                                       input logic [WinBits-1:0] m);
    logic [3:0]         n;
    logic [6:0]         sh;
    logic [WinBits-1:0] ms;
    logic               hit;
    n   = marker_len(m);
    sh  = {(4'd8 - n), 3'b000};
    ms  = m >> sh;
    hit = 1'b1;
    for (int j = 0; j < 8; j++) begin
      if ((4'(j) < n) && (tail[8*j +: 8] != ms[8*j +: 8])) begin
        hit = 1'b0;
      end
    end
    return (n != 4'd0) && (TlenBits'(n) <= tlen) && hit;
  endfunction

  function automatic logic [OutBits-1:0] out_sat(input logic [65:0] v);
    return (v > 66'({OutBits{1'b1}})) ? {OutBits{1'b1}} : v[OutBits-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/slc_line_tracker.sv =====
// Byte intake: whitespace trimming, head/tail windows and line snapshot register.
`default_nettype none

`include "source_line_classifier_macros.svh"

module slc_line_tracker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          text_byte_i,
  input  wire logic                has_byte_i,
  input  wire logic                end_of_file_i,
  output logic                     snap_valid_o,
  input  wire logic                snap_ready_i,
  output slc_pkg::line_snap_t      snap_o
);

  logic                              seen_q, seen_d;
  logic                              has_q, has_d;
  logic [slc_pkg::WinBits-1:0]       head_q, head_d;
  logic [slc_pkg::WinBits-1:0]       tail_q, tail_d;
  logic [slc_pkg::WinBits-1:0]       ps_q, ps_d;
  logic [slc_pkg::PscBits-1:0]       psc_q, psc_d;
  logic [slc_pkg::TlenBits-1:0]      tlen_q, tlen_d;

  logic                              snap_valid_q;
  slc_pkg::line_snap_t               snap_q, snap_d;

  logic                              take;
  logic                              is_nl;
  logic                              is_ws;
  logic                              gen;
  logic [5:0]                        fill;
  logic [5:0]                        tsum;
  logic [3:0]                        k;
  logic [6:0]                        sh;
  logic [slc_pkg::WinBits-1:0]       tmask;
  logic [slc_pkg::WinBits-1:0]       ttmp;

  assign in_ready_o = !snap_valid_q || snap_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign is_nl      = has_byte_i && (text_byte_i == 8'h0A);
  assign is_ws      = (text_byte_i == 8'h20) ||
                      ((text_byte_i >= 8'h09) && (text_byte_i <= 8'h0D));
  assign gen        = is_nl || end_of_file_i;

  assign fill  = 6'(tlen_q) + 6'(psc_q);
  assign tsum  = 6'(tlen_q) + 6'(psc_q) + 6'd1;
  assign k     = (psc_q >= 4'd8) ? 4'd8 : psc_q;
  assign sh    = {k, 3'b000};
  assign tmask = ~({slc_pkg::WinBits{1'b1}} << sh);
  assign ttmp  = (tail_q << sh) | (ps_q & tmask);

  // Line state after this byte, as if the line went on.
  always_comb begin
    seen_d = seen_q;
    has_d  = has_q;
    head_d = head_q;
    tail_d = tail_q;
    ps_d   = ps_q;
    psc_d  = psc_q;
    tlen_d = tlen_q;
    if (has_byte_i && !is_nl) begin
      has_d = 1'b1;
      if (!is_ws || seen_q) begin
        if (fill < 6'd8) begin
          head_d[63-8*fill[2:0] -: 8] = text_byte_i;
        end
      end
      if (is_ws) begin
        if (seen_q) begin
          ps_d  = {ps_q[55:0], text_byte_i};
          psc_d = (psc_q == 4'd15) ? psc_q : psc_q + 4'd1;
        end
      end else begin
        seen_d = 1'b1;
        tail_d = {ttmp[55:0], text_byte_i};
        tlen_d = (tsum > 6'd31) ? 5'd31 : tsum[4:0];
        ps_d   = '0;
        psc_d  = '0;
      end
    end
  end

  // A newline snapshots the line as it stood; end of file takes the updated line.
  always_comb begin
    snap_d.eof = end_of_file_i;
    if (is_nl) begin
      snap_d.cls  = 1'b1;
      snap_d.head = head_q;
      snap_d.tail = tail_q;
      snap_d.tlen = tlen_q;
    end else begin
      snap_d.cls  = has_d;
      snap_d.head = head_d;
      snap_d.tail = tail_d;
      snap_d.tlen = tlen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      has_q        <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      ps_q         <= '0;
      psc_q        <= '0;
      tlen_q       <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      if (take) begin
        if (gen) begin
          seen_q <= 1'b0;
          has_q  <= 1'b0;
          head_q <= '0;
          tail_q <= '0;
          ps_q   <= '0;
          psc_q  <= '0;
          tlen_q <= '0;
        end else begin
          seen_q <= seen_d;
          has_q  <= has_d;
          head_q <= head_d;
          tail_q <= tail_d;
          ps_q   <= ps_d;
          psc_q  <= psc_d;
          tlen_q <= tlen_d;
        end
      end
      if (in_ready_o) begin
        snap_valid_q <= take && gen;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && gen) begin
      snap_q <= snap_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  `SLC_ASSERT_NOW(a_tail_needs_text, tlen_q == '0, tail_q == '0,
    "tail window holds bytes with no trimmed text")
  `SLC_ASSERT_NOW(a_lead_ws_dropped, !seen_q,
    (psc_q == '0) && (tlen_q == '0) && (head_q == '0),
    "line state grew before the first non-space byte")

endmodule

`default_nettype wire

// ===== rtl/slc_classifier.sv =====
// Line classing, block-comment tracking, running counts and the result register.
`default_nettype none

`include "source_line_classifier_macros.svh"

module slc_classifier (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire slc_pkg::marker_set_t          markers_i,
  input  wire logic                          snap_valid_i,
  output logic                               snap_ready_o,
  input  wire slc_pkg::line_snap_t           snap_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               line_valid_o,
  output logic [1:0]                         line_class_o,
  output logic [slc_pkg::OutBits-1:0]        code_count_o,
  output logic [slc_pkg::OutBits-1:0]        comment_count_o,
  output logic [slc_pkg::OutBits-1:0]        blank_count_o,
  output logic [slc_pkg::OutBits-1:0]        total_count_o,
  output logic                               in_block_o,
  output logic                               file_done_o
);

  localparam logic [slc_pkg::CountBits-1:0] CntMax = {slc_pkg::CountBits{1'b1}};
  localparam logic [slc_pkg::CountBits-1:0] CntOne = {{(slc_pkg::CountBits-1){1'b0}}, 1'b1};

  logic                               in_block_q, in_block_d;
  logic [slc_pkg::CountBits-1:0]      code_q, code_d;
  logic [slc_pkg::CountBits-1:0]      comment_q, comment_d;
  logic [slc_pkg::CountBits-1:0]      blank_q, blank_d;
  slc_pkg::line_class_e               cls_d;

  logic                               out_valid_q;
  logic                               line_valid_q;
  slc_pkg::line_class_e               line_class_q;
  logic [slc_pkg::OutBits-1:0]        code_out_q, comment_out_q, blank_out_q, total_out_q;
  logic                               in_block_out_q;
  logic                               file_done_q;

  logic                               fire;
  logic                               sw_single, sw_open, sw_open_alt;
  logic                               ew_close, ew_close_alt;
  logic                               whole_block;
  logic [slc_pkg::CountBits+1:0]      sum;
  logic [slc_pkg::CountBits-1:0]      total_sat;

  assign snap_ready_o = !out_valid_q || out_ready_i;
  assign fire         = snap_valid_i && snap_ready_o;

  assign sw_single   = slc_pkg::leads_with(snap_i.head, snap_i.tlen, markers_i.single_m) ||
                       slc_pkg::leads_with(snap_i.head, snap_i.tlen, markers_i.single_alt_m);
  assign sw_open     = slc_pkg::leads_with(snap_i.head, snap_i.tlen, markers_i.open_m);
  assign sw_open_alt = slc_pkg::leads_with(snap_i.head, snap_i.tlen, markers_i.open_alt_m);
  assign ew_close    = slc_pkg::trails_with(snap_i.tail, snap_i.tlen, markers_i.close_m);
  assign ew_close_alt = slc_pkg::trails_with(snap_i.tail, snap_i.tlen, markers_i.close_alt_m);
  assign whole_block = (sw_open && ew_close) || (sw_open_alt && ew_close_alt);

  always_comb begin
    in_block_d = in_block_q;
    code_d     = code_q;
    comment_d  = comment_q;
    blank_d    = blank_q;
    cls_d      = slc_pkg::ClassBlank;
    if (snap_i.cls) begin
      if (snap_i.tlen == '0) begin
        blank_d = (blank_q == CntMax) ? blank_q : blank_q + CntOne;
      end else begin
        cls_d = slc_pkg::ClassComment;
        if (sw_single || whole_block) begin
          cls_d = slc_pkg::ClassComment;
        end else if (in_block_q) begin
          if (ew_close || ew_close_alt) begin
            in_block_d = 1'b0;
          end
        end else if (sw_open || sw_open_alt) begin
          in_block_d = 1'b1;
        end else begin
          cls_d = slc_pkg::ClassCode;
        end
        if (cls_d == slc_pkg::ClassCode) begin
          // A saturated comment count loses one on a code line.
          comment_d = (comment_q == CntMax) ? CntMax - CntOne : comment_q;
          code_d    = (code_q == CntMax) ? code_q : code_q + CntOne;
        end else begin
          comment_d = (comment_q == CntMax) ? comment_q : comment_q + CntOne;
        end
      end
    end
  end

  assign sum = (slc_pkg::CountBits+2)'(code_d) + (slc_pkg::CountBits+2)'(comment_d) +
               (slc_pkg::CountBits+2)'(blank_d);
  assign total_sat = (sum > (slc_pkg::CountBits+2)'(CntMax)) ? CntMax
                                                             : sum[slc_pkg::CountBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_block_q  <= 1'b0;
      code_q      <= '0;
      comment_q   <= '0;
      blank_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        if (snap_i.eof) begin
          in_block_q <= 1'b0;
          code_q     <= '0;
          comment_q  <= '0;
          blank_q    <= '0;
        end else begin
          in_block_q <= in_block_d;
          code_q     <= code_d;
          comment_q  <= comment_d;
          blank_q    <= blank_d;
        end
      end
      if (snap_ready_o) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      line_valid_q   <= snap_i.cls;
      line_class_q   <= cls_d;
      code_out_q     <= slc_pkg::out_sat(66'(code_d));
      comment_out_q  <= slc_pkg::out_sat(66'(comment_d));
      blank_out_q    <= slc_pkg::out_sat(66'(blank_d));
      total_out_q    <= slc_pkg::out_sat(66'(total_sat));
      in_block_out_q <= in_block_d;
      file_done_q    <= snap_i.eof;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_valid_o    = line_valid_q;
  assign line_class_o    = line_class_q;
  assign code_count_o    = code_out_q;
  assign comment_count_o = comment_out_q;
  assign blank_count_o   = blank_out_q;
  assign total_count_o   = total_out_q;
  assign in_block_o      = in_block_out_q;
  assign file_done_o     = file_done_q;

  `SLC_ASSERT_NEXT(a_eof_clears, fire && snap_i.eof,
    (code_q == '0) && (comment_q == '0) && (blank_q == '0) && !in_block_q,
    "counts or block state survived end of file")
  `SLC_ASSERT_NOW(a_bare_eof, out_valid_q && !line_valid_q,
    file_done_q && (line_class_q == slc_pkg::ClassBlank),
    "result without a line that is not an end of file")

endmodule

`default_nettype wire

// ===== rtl/source_line_classifier.sv =====
// Top level of the source line classifier: marker registers and the two pipeline stages.
//
// Text enters on the in_ channel, one item per ready cycle: text_byte_i, with has_byte_i
// marking it as part of the file and end_of_file_i closing the file after it.
// Byte 0x0A ends a line; each finished line is classed blank, comment or code and
// comes out on the out_ channel with the running counts and the block-comment flag.
// An end of file always gives a result with file_done_o set, after which the counts
// and the block state clear. Items that end no line give no result.
// Markers are written on the cfg_ channel (index selects the register, ready is
// always high) and are expected to change only while the block is idle.
// Throughput is one item per cycle while out_ready_i is high. An accepted item is
// registered as a line snapshot, and the snapshot is then classed into the result
// register, from which the result is shown.
// If the receiver stalls, the result register holds, one more line snapshot can
// wait behind it, and the input is held off only while that snapshot is waiting.
// Reset clears all markers, counts, line state and both valid flags.
`default_nettype none

module source_line_classifier (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [slc_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  wire logic [slc_pkg::WinBits-1:0]        cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [7:0]                         text_byte_i,
  input  wire logic                               has_byte_i,
  input  wire logic                               end_of_file_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    line_valid_o,
  output logic [1:0]                              line_class_o,
  output logic [slc_pkg::OutBits-1:0]             code_count_o,
  output logic [slc_pkg::OutBits-1:0]             comment_count_o,
  output logic [slc_pkg::OutBits-1:0]             blank_count_o,
  output logic [slc_pkg::OutBits-1:0]             total_count_o,
  output logic                                    in_block_o,
  output logic                                    file_done_o
);

  slc_pkg::marker_set_t markers_q;
  logic                 snap_valid;
  logic                 snap_ready;
  slc_pkg::line_snap_t  snap;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      markers_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        slc_pkg::CfgSingle:        markers_q.single_m     <= cfg_data_i;
        slc_pkg::CfgSingleAlt:     markers_q.single_alt_m <= cfg_data_i;
        slc_pkg::CfgBlockOpen:     markers_q.open_m       <= cfg_data_i;
        slc_pkg::CfgBlockClose:    markers_q.close_m      <= cfg_data_i;
        slc_pkg::CfgBlockOpenAlt:  markers_q.open_alt_m   <= cfg_data_i;
        slc_pkg::CfgBlockCloseAlt: markers_q.close_alt_m  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  slc_line_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .has_byte_i    (has_byte_i),
    .end_of_file_i (end_of_file_i),
    .snap_valid_o  (snap_valid),
    .snap_ready_i  (snap_ready),
    .snap_o        (snap)
  );

  slc_classifier u_classifier (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .markers_i       (markers_q),
    .snap_valid_i    (snap_valid),
    .snap_ready_o    (snap_ready),
    .snap_i          (snap),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .line_valid_o    (line_valid_o),
    .line_class_o    (line_class_o),
    .code_count_o    (code_count_o),
    .comment_count_o (comment_count_o),
    .blank_count_o   (blank_count_o),
    .total_count_o   (total_count_o),
    .in_block_o      (in_block_o),
    .file_done_o     (file_done_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_source_line_classifier.sv =====
// Self-checking testbench for the source line classifier: random text against a line tally.
`timescale 1ns / 1ps

module tb_source_line_classifier;

  typedef struct packed {
    logic                        line_valid;
    slc_pkg::line_class_e        cls;
    logic [slc_pkg::OutBits-1:0] code;
    logic [slc_pkg::OutBits-1:0] comment;
    logic [slc_pkg::OutBits-1:0] blank;
    logic [slc_pkg::OutBits-1:0] total;
    logic                        in_block;
    logic                        file_done;
  } line_result_t;

  // Tracks line state and running counts, queues the result each text item should give.
  class line_tally_checker;
    logic [slc_pkg::WinBits-1:0]   marker [6];
    logic                          in_blk, line_has, seen_text;
    logic [slc_pkg::WinBits-1:0]   head_w, tail_w, ws_hold;
    int unsigned                   ws_cnt, tlen;
    logic [slc_pkg::CountBits-1:0] n_code, n_comment, n_blank;
    line_result_t                  due_lines[$];
    int                            mismatches;

    function new();
      foreach (marker[i]) marker[i] = '0;
      in_blk     = 1'b0;
      n_code     = '0;
      n_comment  = '0;
      n_blank    = '0;
      mismatches = 0;
      new_line();
    endfunction

    function void set_marker(slc_pkg::cfg_reg_e r, logic [slc_pkg::WinBits-1:0] v);
      marker[r] = v;
    endfunction

    function int pending();
      return due_lines.size();
    endfunction

    function int unsigned mark_len(logic [slc_pkg::WinBits-1:0] m);
      int unsigned n;
      n = 0;
      while (n < slc_pkg::MarkerBytes && n < 8 && m[63-8*n -: 8] != 8'h00) n++;
      return n;
    endfunction

    function logic head_match(logic [slc_pkg::WinBits-1:0] m);
      int unsigned n, sh;
      n = mark_len(m);
      if (n == 0 || tlen < n) return 1'b0;
      sh = 8 * (8 - n);
      return (head_w >> sh) == (m >> sh);
    endfunction

    function logic tail_match(logic [slc_pkg::WinBits-1:0] m);
      int unsigned n;
      logic [slc_pkg::WinBits-1:0] mask;
      n = mark_len(m);
      if (n == 0 || tlen < n) return 1'b0;
      mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      return (tail_w & mask) == (m >> (8 * (8 - n)));
    endfunction

    function void new_line();
      line_has  = 1'b0;
      seen_text = 1'b0;
      head_w    = '0;
      tail_w    = '0;
      ws_hold   = '0;
      ws_cnt    = 0;
      tlen      = 0;
    endfunction

    function void head_push(logic [7:0] b);
      int unsigned fill;
      fill = tlen + ws_cnt;
      if (fill < 8) head_w |= 64'(b) << (8 * (7 - fill));
    endfunction

    function void take(logic [7:0] b);
      logic        ws;
      int unsigned k;
      ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
      line_has = 1'b1;
      if (ws) begin
        if (!seen_text) return;
        head_push(b);
        ws_hold = {ws_hold[55:0], b};
        if (ws_cnt < 15) ws_cnt++;
        return;
      end
      seen_text = 1'b1;
      head_push(b);
      k = (ws_cnt < 8) ? ws_cnt : 8;
      // held trailing whitespace becomes interior text once a visible byte follows
      if (k == 8) begin
        tail_w = ws_hold;
      end else if (k > 0) begin
        tail_w = (tail_w << (8 * k)) | (ws_hold & ((64'd1 << (8 * k)) - 64'd1));
      end
      tail_w = {tail_w[55:0], b};
      tlen   = tlen + ws_cnt + 1;
      if (tlen > 31) tlen = 31;
      ws_hold = '0;
      ws_cnt  = 0;
    endfunction

    function slc_pkg::line_class_e classify();
      logic close_end;
      if (tlen == 0) begin
        if (n_blank != '1) n_blank++;
        return slc_pkg::ClassBlank;
      end
      if (n_comment != '1) n_comment++;
      if (head_match(marker[slc_pkg::CfgSingle]) ||
          head_match(marker[slc_pkg::CfgSingleAlt]))
        return slc_pkg::ClassComment;
      if ((mark_len(marker[slc_pkg::CfgBlockClose]) != 0 &&
           head_match(marker[slc_pkg::CfgBlockOpen]) &&
           tail_match(marker[slc_pkg::CfgBlockClose])) ||
          (mark_len(marker[slc_pkg::CfgBlockCloseAlt]) != 0 &&
           head_match(marker[slc_pkg::CfgBlockOpenAlt]) &&
           tail_match(marker[slc_pkg::CfgBlockCloseAlt])))
        return slc_pkg::ClassComment;
      close_end = tail_match(marker[slc_pkg::CfgBlockClose]) ||
                  tail_match(marker[slc_pkg::CfgBlockCloseAlt]);
      if (in_blk) begin
        if (close_end) in_blk = 1'b0;
        return slc_pkg::ClassComment;
      end
      if (head_match(marker[slc_pkg::CfgBlockOpen]) ||
          head_match(marker[slc_pkg::CfgBlockOpenAlt])) begin
        in_blk = 1'b1;
        return slc_pkg::ClassComment;
      end
      n_comment--;
      if (n_code != '1) n_code++;
      return slc_pkg::ClassCode;
    endfunction

    function void take_text_item(logic [7:0] b, logic has, logic eof);
      logic                 valid;
      slc_pkg::line_class_e cls;
      logic [33:0]          sum;
      line_result_t         r;
      valid = 1'b0;
      cls   = slc_pkg::ClassBlank;
      if (has) begin
        if (b == 8'h0A) begin
          cls   = classify();
          valid = 1'b1;
          new_line();
        end else begin
          take(b);
        end
      end
      if (eof && line_has) begin
        cls   = classify();
        valid = 1'b1;
        new_line();
      end
      if (!valid && !eof) return;
      sum = 34'(n_code) + 34'(n_comment) + 34'(n_blank);
      r.line_valid = valid;
      r.cls        = cls;
      r.code       = n_code;
      r.comment    = n_comment;
      r.blank      = n_blank;
      r.total      = (sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      r.in_block   = in_blk;
      r.file_done  = eof;
      due_lines.push_back(r);
      if (eof) begin
        in_blk    = 1'b0;
        new_line();
        n_code    = '0;
        n_comment = '0;
        n_blank   = '0;
      end
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_line_result(line_result_t got);
      line_result_t want;
      if (due_lines.size() == 0) begin
        flag_mismatch("result with nothing pending", got.line_valid, 0);
        return;
      end
      want = due_lines.pop_front();
      if (got.line_valid !== want.line_valid)
        flag_mismatch("line_valid", got.line_valid, want.line_valid);
      if (got.cls !== want.cls) flag_mismatch("line_class", got.cls, want.cls);
      if (got.code !== want.code) flag_mismatch("code_count", got.code, want.code);
      if (got.comment !== want.comment)
        flag_mismatch("comment_count", got.comment, want.comment);
      if (got.blank !== want.blank) flag_mismatch("blank_count", got.blank, want.blank);
      if (got.total !== want.total) flag_mismatch("total_count", got.total, want.total);
      if (got.in_block !== want.in_block)
        flag_mismatch("in_block", got.in_block, want.in_block);
      if (got.file_done !== want.file_done)
        flag_mismatch("file_done", got.file_done, want.file_done);
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [slc_pkg::CfgIdxBits-1:0] cfg_index_i = slc_pkg::CfgSingle;
  logic [slc_pkg::WinBits-1:0]    cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [7:0]                     text_byte_i = 8'h00;
  logic                           has_byte_i = 1'b0;
  logic                           end_of_file_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic                           line_valid_o;
  logic [1:0]                     line_class_o;
  logic [slc_pkg::OutBits-1:0]    code_count_o, comment_count_o, blank_count_o, total_count_o;
  logic                           in_block_o, file_done_o;

  line_tally_checker           tally;
  logic [slc_pkg::WinBits-1:0] marker_sets [6][6];
  logic [7:0]                  line_bytes[$];
  int                          cur_set;
  int                          text_items = 0;
  int                          tx_idle_pct = 0;
  int                          rx_idle_pct = 0;
  int                          hold_asks = 0;

  source_line_classifier u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .text_byte_i     (text_byte_i),
    .has_byte_i      (has_byte_i),
    .end_of_file_i   (end_of_file_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .line_valid_o    (line_valid_o),
    .line_class_o    (line_class_o),
    .code_count_o    (code_count_o),
    .comment_count_o (comment_count_o),
    .blank_count_o   (blank_count_o),
    .total_count_o   (total_count_o),
    .in_block_o      (in_block_o),
    .file_done_o     (file_done_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("[source_line_classifier] ERROR");
    $finish;
  end

  // Receiver: checks results, stalls at random, and on request holds off for a long stretch.
  initial begin : rx_side
    int           hold_left;
    int           hold_served;
    line_result_t got;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.line_valid = line_valid_o;
        got.cls        = slc_pkg::line_class_e'(line_class_o);
        got.code       = code_count_o;
        got.comment    = comment_count_o;
        got.blank      = blank_count_o;
        got.total      = total_count_o;
        got.in_block   = in_block_o;
        got.file_done  = file_done_o;
        tally.check_line_result(got);
      end
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left   = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [slc_pkg::WinBits-1:0] pack_marker(string s);
    logic [slc_pkg::WinBits-1:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[63-8*i -: 8] = s[i];
    return v;
  endfunction

  task automatic send_item(logic [7:0] b, logic has, logic eof);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    has_byte_i    <= has;
    end_of_file_i <= eof;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tally.take_text_item(b, has, eof);
    if (has || eof) text_items++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, 1'b0);
  endtask

  // Sender stops and waits for every outstanding line result.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tally.pending() != 0);
  endtask

  task automatic write_markers(int set);
    slc_pkg::cfg_reg_e r;
    r = r.first();
    repeat (6) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i  <= marker_sets[set][r];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      tally.set_marker(r, marker_sets[set][r]);
      r = r.next();
    end
    cfg_valid_i <= 1'b0;
    cur_set = set;
  endtask

  function automatic logic [7:0] pick_ws();
    logic [7:0] ws_pool [5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    return ws_pool[$urandom_range(4)];
  endfunction

  function automatic void push_marker(slc_pkg::cfg_reg_e r);
    logic [slc_pkg::WinBits-1:0] m;
    m = marker_sets[cur_set][r];
    for (int i = 0; i < int'(tally.mark_len(m)); i++) line_bytes.push_back(m[63-8*i -: 8]);
  endfunction

  // One line: mostly shaped around the current markers, some blank, some raw noise.
  task automatic emit_line();
    int shape, n, fin;
    line_bytes.delete();
    shape = $urandom_range(99);
    if (shape < 12) begin
      repeat ($urandom_range(10)) line_bytes.push_back(8'($urandom_range(255)));
    end else if (shape < 22) begin
      n = ($urandom_range(5) == 0) ? $urandom_range(9, 20) : $urandom_range(4);
      repeat (n) line_bytes.push_back(pick_ws());
    end else begin
      repeat ($urandom_range(2)) line_bytes.push_back(pick_ws());
      case ($urandom_range(7))
        1: push_marker(slc_pkg::CfgSingle);
        2: push_marker(slc_pkg::CfgSingleAlt);
        3: push_marker(slc_pkg::CfgBlockOpen);
        4: push_marker(slc_pkg::CfgBlockClose);
        5: push_marker(slc_pkg::CfgBlockOpenAlt);
        6: push_marker(slc_pkg::CfgBlockCloseAlt);
        default: ;
      endcase
      n = ($urandom_range(19) == 0) ? $urandom_range(25, 40) : $urandom_range(6);
      repeat (n) begin
        if ($urandom_range(5) == 0) line_bytes.push_back(pick_ws());
        else line_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
      case ($urandom_range(5))
        0: push_marker(slc_pkg::CfgBlockClose);
        1: push_marker(slc_pkg::CfgBlockCloseAlt);
        2: push_marker(slc_pkg::CfgBlockOpen);
        default: ;
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(8, 18) : $urandom_range(2);
      repeat (n) line_bytes.push_back(pick_ws());
    end
    foreach (line_bytes[i]) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(line_bytes[i], 1'b1, 1'b0);
    end
    fin = $urandom_range(99);
    if (fin < 4) begin
      send_item(8'h0A, 1'b1, 1'b1);
    end else if (fin < 8) begin
      send_item(8'($urandom_range(255)), 1'b1, 1'b1);
    end else if (fin < 11) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      send_item(8'h0A, 1'b1, 1'b0);
      // end of file with no line open
      if ($urandom_range(49) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  initial begin : main_seq
    int phase_set [6] = '{1, 2, 3, 4, 5, 0};
    int goal;
    logic paused;
    tally = new();
    foreach (marker_sets[s, r]) marker_sets[s][r] = '0;
    marker_sets[0][slc_pkg::CfgSingle]        = pack_marker("//");
    marker_sets[0][slc_pkg::CfgSingleAlt]     = pack_marker("#");
    marker_sets[0][slc_pkg::CfgBlockOpen]     = pack_marker("/*");
    marker_sets[0][slc_pkg::CfgBlockClose]    = pack_marker("*/");
    marker_sets[0][slc_pkg::CfgBlockOpenAlt]  = pack_marker("(*");
    marker_sets[0][slc_pkg::CfgBlockCloseAlt] = pack_marker("*)");
    // set 1 stays all zero: no markers at all
    marker_sets[2][slc_pkg::CfgSingle]        = 64'hFFFF_FFFF_FFFF_FFFF;
    marker_sets[2][slc_pkg::CfgSingleAlt]     = pack_marker("--------");
    marker_sets[2][slc_pkg::CfgBlockOpen]     = pack_marker("<<<<<<<<");
    marker_sets[2][slc_pkg::CfgBlockClose]    = pack_marker(">>>>>>>>");
    // bytes after the first zero byte must be ignored
    marker_sets[2][slc_pkg::CfgBlockOpenAlt]  = 64'h7B00_2100_0000_0000;
    marker_sets[2][slc_pkg::CfgBlockCloseAlt] = 64'h7D00_FF00_0000_0000;
    marker_sets[3][slc_pkg::CfgSingle]        = pack_marker("--");
    marker_sets[3][slc_pkg::CfgBlockOpen]     = pack_marker("{-");
    marker_sets[3][slc_pkg::CfgBlockClose]    = pack_marker("-}");
    marker_sets[3][slc_pkg::CfgBlockOpenAlt]  = pack_marker("<!--");
    marker_sets[3][slc_pkg::CfgBlockCloseAlt] = pack_marker("-->");
    // open marker with no close of its own: only the alternate close or end of file ends its block
    marker_sets[4][slc_pkg::CfgSingle]        = pack_marker(";");
    marker_sets[4][slc_pkg::CfgSingleAlt]     = pack_marker("REM");
    marker_sets[4][slc_pkg::CfgBlockOpen]     = pack_marker("%{");
    marker_sets[4][slc_pkg::CfgBlockOpenAlt]  = pack_marker("\"\"\"");
    marker_sets[4][slc_pkg::CfgBlockCloseAlt] = pack_marker("\"\"\"");
    marker_sets[5][slc_pkg::CfgSingleAlt]     = pack_marker("!");
    marker_sets[5][slc_pkg::CfgBlockOpen]     = pack_marker("/*");
    marker_sets[5][slc_pkg::CfgBlockClose]    = pack_marker("*/");
    marker_sets[5][slc_pkg::CfgBlockOpenAlt]  = pack_marker("{");
    marker_sets[5][slc_pkg::CfgBlockCloseAlt] = pack_marker("}");

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_markers(0);

    send_string("\n");
    send_string(" \n");
    send_string("//\n");
    send_string("x\n");
    send_string("/*\n");
    send_string("a\n");
    send_string("*/\n");
    send_string("/**/\n");
    send_item(8'h0A, 1'b0, 1'b0);
    send_item("y", 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);

    for (int p = 0; p < 6; p++) begin
      drain_results();
      repeat (4) @(posedge clk_i);
      write_markers(phase_set[p]);
      tx_idle_pct = (p < 2) ? 14 : (p < 4) ? 48 : 0;
      rx_idle_pct = (p < 2) ? 48 : (p < 4) ? 14 : 0;
      if (p == 4) hold_asks <= hold_asks + 1;
      goal   = text_items + 215;
      paused = 1'b0;
      while (text_items < goal) begin
        emit_line();
        if (p == 2 && !paused && text_items > goal - 100) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    repeat (6) @(posedge clk_i);
    if (tally.mismatches == 0 && tally.pending() == 0) begin
      $display("[source_line_classifier] OK");
    end else begin
      $display("[source_line_classifier] ERROR");
    end
    $finish;
  end

endmodule
